### rtl/core/mktt_pkg.sv
package mktt_pkg;

  // Default table depth and the timeout that reset loads.
  localparam int unsigned ENTRIES_DEFAULT = 16;
  localparam logic [31:0] TIMEOUT_RESET   = 32'd30000;

  typedef enum logic [1:0] {
    OP_OBSERVE = 2'd0,
    OP_SWEEP   = 2'd1,
    OP_READ    = 2'd2,
    OP_CLEAR   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    STATUS_MATCHED = 2'd0,
    STATUS_NEW     = 2'd1,
    STATUS_EVICTED = 2'd2,
    STATUS_NONE    = 2'd3
  } status_e;

  // One stored table entry; the valid bit lives in flip-flops beside it.
  typedef struct packed {
    logic [47:0] mac;
    logic [7:0]  rssi;
    logic [7:0]  channel;
    logic [31:0] seen_ms;
  } entry_t;

  // Flags produced by the shared compare unit for one entry.
  typedef struct packed {
    logic mac_hit;
    logic older;
    logic expired;
  } eval_t;

endpackage

### rtl/core/mktt_eval.sv
// Shared compare unit: key match, age order and timeout test for one entry.
module mktt_eval (
  input  mktt_pkg::entry_t entry_i,
  input  logic [47:0]      key_mac_i,
  input  logic [31:0]      oldest_ms_i,
  input  logic [31:0]      now_ms_i,
  input  logic [31:0]      timeout_ms_i,
  output mktt_pkg::eval_t  eval_o
);

  logic [31:0] age;

  // The age wraps modulo 2^32, as the millisecond clock does.
  assign age = now_ms_i - entry_i.seen_ms;

  assign eval_o.mac_hit = (entry_i.mac == key_mac_i);
  assign eval_o.older   = (entry_i.seen_ms < oldest_ms_i);
  assign eval_o.expired = (age > timeout_ms_i);

endmodule

### rtl/core/mac_keyed_tracking_table_core.sv
// Table of radio transmitters keyed by a 48-bit MAC address.
//
// Input channel (in_valid_i / in_ready_o) carries one operation per beat:
// observe, sweep, read last-updated entry, or clear. Every accepted beat
// yields exactly one result beat on the output channel (out_valid_o /
// out_ready_i). The timeout register is written through cfg_we_i and
// cfg_wdata_i, only while the block is idle: a rule for the user, not enforced.
//
// Observe and sweep walk the whole table through the shared compare unit,
// one entry per cycle behind the registered memory read, and answer from
// the commit state once the scan has drained; a read passes through a read
// state and a read-done state, and a clear answers in the cycle right after
// acceptance. A new beat is taken only once the result has left, so an
// observe or sweep never overlaps the one before it.
//
// Reset clears every valid bit, the last-updated marker and the
// observation counter, and loads a timeout of 30000 ms; the entry memory
// itself needs no clearing, since only valid entries are ever read out.
// When the receiver stalls, the result is held in the output register and
// no new beat is accepted until it has been taken.
module mac_keyed_tracking_table_core #(
  parameter int unsigned ENTRIES = mktt_pkg::ENTRIES_DEFAULT
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         operation_i,
  input  logic [47:0]        mac_i,
  input  logic signed [7:0]  rssi_i,
  input  logic [7:0]         channel_i,
  input  logic [31:0]        now_ms_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic [3:0]         slot_o,
  output logic [1:0]         entry_status_o,
  output logic [4:0]         active_count_o,
  output logic [31:0]        total_seen_o,
  output logic               found_o,
  output logic [47:0]        entry_mac_o,
  output logic signed [7:0]  entry_rssi_o,
  output logic [7:0]         entry_channel_o,
  output logic [31:0]        entry_seen_ms_o
);

  localparam int unsigned IW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int unsigned CW = $clog2(ENTRIES + 1);
  localparam logic [IW-1:0] LAST = IW'(ENTRIES - 1);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_COMMIT,
    S_READ,
    S_READ_DONE
  } state_e;

  state_e state_q;

  // Captured input beat.
  mktt_pkg::op_e op_q;
  logic [47:0]   mac_q;
  logic [7:0]    rssi_q;
  logic [7:0]    channel_q;
  logic [31:0]   now_q;

  // Table state held in flip-flops.
  logic [ENTRIES-1:0] valid_q;
  logic               has_last_q;
  logic [IW-1:0]      last_idx_q;
  logic [31:0]        seen_cnt_q;
  logic [31:0]        timeout_q;

  // Scan sequencer and trackers.
  logic [IW-1:0] idx_q;
  logic          pend_q;
  logic [IW-1:0] pend_idx_q;
  logic          match_q, free_q, old_q;
  logic [IW-1:0] match_idx_q, free_idx_q, old_idx_q;
  logic [31:0]   old_ms_q;
  logic [CW-1:0] count_q;

  // Output register.
  logic          out_valid_q;
  logic [3:0]    slot_q;
  logic [1:0]    status_q;
  logic [4:0]    active_q;
  logic [31:0]   total_q;
  logic          found_q;
  logic [47:0]   emac_q;
  logic [7:0]    erssi_q;
  logic [7:0]    echan_q;
  logic [31:0]   eseen_q;

  // Entry memory: one write port, one registered read port.
  mktt_pkg::entry_t mem [ENTRIES];
  mktt_pkg::entry_t rdata_q;
  mktt_pkg::entry_t wdata;
  logic             mem_we;
  logic [IW-1:0]    mem_raddr;

  mktt_pkg::eval_t ev;

  // Slot chosen by an observe once the scan is complete.
  logic [IW-1:0]         sel_idx;
  mktt_pkg::status_e     sel_status;
  logic [IW+3:0]         sel_wide;
  logic [IW+3:0]         last_wide;
  logic [CW+4:0]         count_wide;

  always_comb begin
    if (match_q) begin
      sel_idx    = match_idx_q;
      sel_status = mktt_pkg::STATUS_MATCHED;
    end else if (free_q) begin
      sel_idx    = free_idx_q;
      sel_status = mktt_pkg::STATUS_NEW;
    end else begin
      sel_idx    = old_idx_q;
      sel_status = mktt_pkg::STATUS_EVICTED;
    end
  end

  assign sel_wide   = {4'b0, sel_idx};
  assign last_wide  = {4'b0, last_idx_q};
  assign count_wide = {5'b0, count_q};

  assign mem_we    = (state_q == S_COMMIT) && (op_q == mktt_pkg::OP_OBSERVE);
  assign mem_raddr = (state_q == S_READ) ? last_idx_q : idx_q;
  assign wdata     = '{mac: mac_q, rssi: rssi_q, channel: channel_q, seen_ms: now_q};

  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem[sel_idx] <= wdata;
    end
    rdata_q <= mem[mem_raddr];
  end

  mktt_eval u_eval (
    .entry_i      (rdata_q),
    .key_mac_i    (mac_q),
    .oldest_ms_i  (old_ms_q),
    .now_ms_i     (now_q),
    .timeout_ms_i (timeout_q),
    .eval_o       (ev)
  );

  assign in_ready_o = (state_q == S_IDLE) && !out_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      valid_q     <= '0;
      has_last_q  <= 1'b0;
      last_idx_q  <= '0;
      seen_cnt_q  <= '0;
      timeout_q   <= mktt_pkg::TIMEOUT_RESET;
      idx_q       <= '0;
      pend_q      <= 1'b0;
      out_valid_q <= 1'b0;
      op_q        <= mktt_pkg::OP_OBSERVE;
    end else begin
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
      if (out_valid_q && out_ready_i) begin
        out_valid_q <= 1'b0;
      end

      pend_q     <= (state_q == S_SCAN);
      pend_idx_q <= idx_q;

      // Evaluate the entry whose read was issued in the previous cycle.
      if (pend_q && op_q == mktt_pkg::OP_OBSERVE) begin
        if (valid_q[pend_idx_q]) begin
          if (!match_q && ev.mac_hit) begin
            match_q     <= 1'b1;
            match_idx_q <= pend_idx_q;
          end
          if (!old_q || ev.older) begin
            old_q     <= 1'b1;
            old_idx_q <= pend_idx_q;
            old_ms_q  <= rdata_q.seen_ms;
          end
        end else if (!free_q) begin
          free_q     <= 1'b1;
          free_idx_q <= pend_idx_q;
        end
      end
      if (pend_q && op_q == mktt_pkg::OP_SWEEP && valid_q[pend_idx_q]) begin
        if (ev.expired) begin
          valid_q[pend_idx_q] <= 1'b0;
        end else begin
          count_q <= CW'(count_q + 1'b1);
        end
      end

      case (state_q)
        S_IDLE: begin
          if (in_valid_i && in_ready_o) begin
            op_q      <= mktt_pkg::op_e'(operation_i);
            mac_q     <= mac_i;
            rssi_q    <= rssi_i;
            channel_q <= channel_i;
            now_q     <= now_ms_i;
            idx_q     <= '0;
            match_q   <= 1'b0;
            free_q    <= 1'b0;
            old_q     <= 1'b0;
            old_ms_q  <= '0;
            count_q   <= '0;
            case (mktt_pkg::op_e'(operation_i))
              mktt_pkg::OP_OBSERVE, mktt_pkg::OP_SWEEP: begin
                state_q <= S_SCAN;
              end
              mktt_pkg::OP_READ: begin
                state_q <= S_READ;
              end
              default: begin
                // Clear: empty the table and answer at once.
                valid_q     <= '0;
                has_last_q  <= 1'b0;
                last_idx_q  <= '0;
                seen_cnt_q  <= '0;
                out_valid_q <= 1'b1;
                slot_q      <= '0;
                status_q    <= mktt_pkg::STATUS_NONE;
                active_q    <= '0;
                total_q     <= '0;
                found_q     <= 1'b0;
                emac_q      <= '0;
                erssi_q     <= '0;
                echan_q     <= '0;
                eseen_q     <= '0;
              end
            endcase
          end
        end
        S_SCAN: begin
          if (idx_q == LAST) begin
            state_q <= S_DRAIN;
          end else begin
            idx_q <= idx_q + 1'b1;
          end
        end
        S_DRAIN: begin
          state_q <= S_COMMIT;
        end
        S_COMMIT: begin
          state_q     <= S_IDLE;
          out_valid_q <= 1'b1;
          found_q     <= 1'b0;
          if (op_q == mktt_pkg::OP_OBSERVE) begin
            valid_q[sel_idx] <= 1'b1;
            has_last_q       <= 1'b1;
            last_idx_q       <= sel_idx;
            seen_cnt_q       <= seen_cnt_q + 32'd1;
            slot_q           <= sel_wide[3:0];
            status_q         <= sel_status;
            active_q         <= '0;
            total_q          <= seen_cnt_q + 32'd1;
            emac_q           <= mac_q;
            erssi_q          <= rssi_q;
            echan_q          <= channel_q;
            eseen_q          <= now_q;
          end else begin
            slot_q   <= '0;
            status_q <= mktt_pkg::STATUS_NONE;
            active_q <= count_wide[4:0];
            total_q  <= seen_cnt_q;
            emac_q   <= '0;
            erssi_q  <= '0;
            echan_q  <= '0;
            eseen_q  <= '0;
          end
        end
        S_READ: begin
          state_q <= S_READ_DONE;
        end
        S_READ_DONE: begin
          state_q     <= S_IDLE;
          out_valid_q <= 1'b1;
          status_q    <= mktt_pkg::STATUS_NONE;
          active_q    <= '0;
          total_q     <= seen_cnt_q;
          if (has_last_q && valid_q[last_idx_q]) begin
            found_q <= 1'b1;
            slot_q  <= last_wide[3:0];
            emac_q  <= rdata_q.mac;
            erssi_q <= rdata_q.rssi;
            echan_q <= rdata_q.channel;
            eseen_q <= rdata_q.seen_ms;
          end else begin
            found_q <= 1'b0;
            slot_q  <= '0;
            emac_q  <= '0;
            erssi_q <= '0;
            echan_q <= '0;
            eseen_q <= '0;
          end
        end
        default: begin
          state_q <= S_IDLE;
        end
      endcase
    end
  end

  assign out_valid_o     = out_valid_q;
  assign slot_o          = slot_q;
  assign entry_status_o  = status_q;
  assign active_count_o  = active_q;
  assign total_seen_o    = total_q;
  assign found_o         = found_q;
  assign entry_mac_o     = emac_q;
  assign entry_rssi_o    = $signed(erssi_q);
  assign entry_channel_o = echan_q;
  assign entry_seen_ms_o = eseen_q;

  // An observe always leaves its chosen slot valid.
  a_observe_sets_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMMIT && op_q == mktt_pkg::OP_OBSERVE) |=> valid_q[$past(sel_idx)])
    else $error("observed slot not valid after commit");

  // No result is pending while an operation is still being worked on.
  a_busy_no_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != S_IDLE) |-> !out_valid_q)
    else $error("result pending while busy");

  // The sweep count cannot exceed the table depth.
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_COMMIT && op_q == mktt_pkg::OP_SWEEP) |-> (count_q <= CW'(ENTRIES)))
    else $error("active count beyond table depth");

  // An observe result implies a last-updated slot is recorded.
  a_observe_has_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && status_q != mktt_pkg::STATUS_NONE) |-> has_last_q)
    else $error("observe result without last-updated slot");

endmodule

### tb/mac_keyed_tracking_table_core_tb.sv
module mac_keyed_tracking_table_core_tb;

  localparam int unsigned ENTRIES        = mktt_pkg::ENTRIES_DEFAULT;
  localparam int unsigned WALK_CYCLES    = ENTRIES + 3;
  localparam int unsigned HOLD_OFF_CYCLES = 300;
  localparam int unsigned MAC_POOL       = 24;
  localparam int unsigned PHASE_ITEMS    = 200;
  localparam int unsigned PHASES         = 6;

  // One result beat, field for field as it leaves the block.
  typedef struct packed {
    logic [3:0]        slot;
    mktt_pkg::status_e status;
    logic [4:0]        active;
    logic [31:0]       total;
    logic              found;
    logic [47:0]       mac;
    logic [7:0]        rssi;
    logic [7:0]        chan;
    logic [31:0]       seen_ms;
  } table_resp_t;

  localparam table_resp_t NONE_RESP =
    '{4'd0, mktt_pkg::STATUS_NONE, 5'd0, 32'd0, 1'b0, 48'h0, 8'h00, 8'h00, 32'h0};

  // One row of the directed script. A row with cfg set writes the timeout register
  // with the value held in now instead of sending a beat. A row with reps above one
  // is sent that many times, the MAC counting up from the given one.
  typedef struct {
    bit            cfg;
    mktt_pkg::op_e op;
    logic [47:0]   mac;
    logic [7:0]    rssi;
    logic [7:0]    chan;
    logic [31:0]   now;
    int unsigned   reps;
    bit            pinned;
    table_resp_t   resp;
  } script_row_t;

  logic              clk_i           = 1'b0;
  logic              rst_ni          = 1'b0;
  logic              cfg_we_i        = 1'b0;
  logic [31:0]       cfg_wdata_i     = '0;
  logic              in_valid_i      = 1'b0;
  logic              in_ready_o;
  logic [1:0]        operation_i     = '0;
  logic [47:0]       mac_i           = '0;
  logic signed [7:0] rssi_i          = '0;
  logic [7:0]        channel_i       = '0;
  logic [31:0]       now_ms_i        = '0;
  logic              out_valid_o;
  logic              out_ready_i     = 1'b0;
  logic [3:0]        slot_o;
  logic [1:0]        entry_status_o;
  logic [4:0]        active_count_o;
  logic [31:0]       total_seen_o;
  logic              found_o;
  logic [47:0]       entry_mac_o;
  logic signed [7:0] entry_rssi_o;
  logic [7:0]        entry_channel_o;
  logic [31:0]       entry_seen_ms_o;

  // A directed row may carry a result typed in by hand; it travels with the beat.
  bit                item_pinned      = 1'b0;
  table_resp_t       item_pinned_resp = NONE_RESP;

  // Shadow of the table, the last-updated marker, the counter and the timeout.
  bit                shadow_valid [ENTRIES];
  bit [47:0]         shadow_mac   [ENTRIES];
  bit [7:0]          shadow_rssi  [ENTRIES];
  bit [7:0]          shadow_chan  [ENTRIES];
  bit [31:0]         shadow_seen  [ENTRIES];
  bit                last_known;
  int unsigned       last_idx;
  bit [31:0]         seen_total;
  bit [31:0]         shadow_timeout = mktt_pkg::TIMEOUT_RESET;

  table_resp_t       response_q [$];
  int unsigned       error_count    = 0;
  int unsigned       send_idle_pct  = 27;
  int unsigned       recv_idle_pct  = 45;
  bit                hold_off_req   = 1'b0;
  logic [47:0]       mac_pool [MAC_POOL];
  logic [31:0]       clock_ms;

  // The directed script. It starts from reset, fills every slot with the largest
  // field values so that the first eviction has to choose among equal times of
  // 0xFFFFFFFF, then checks the tie rule, a match that wins over a lower free
  // slot, the zero and the all-ones timeout, and a clear.
  script_row_t directed_rows [15] = '{
    // Nothing has been observed yet: no entry to read, nothing to count.
    '{1'b0, mktt_pkg::OP_READ,    48'h0, 8'h00, 8'h00, 32'h0, 1, 1'b1, NONE_RESP},
    '{1'b0, mktt_pkg::OP_SWEEP,   48'h0, 8'h00, 8'h00, 32'h0, 1, 1'b1, NONE_RESP},
    '{1'b0, mktt_pkg::OP_OBSERVE, 48'hFFFF_FFFF_FFF0, 8'h7F, 8'hFF, 32'hFFFF_FFFF, 16,
      1'b0, NONE_RESP},
    // Table full, all last seen at the latest possible time: slot 0 must go.
    '{1'b0, mktt_pkg::OP_OBSERVE, 48'h0, 8'h80, 8'h00, 32'h0, 1, 1'b1,
      '{4'd0, mktt_pkg::STATUS_EVICTED, 5'd0, 32'd17, 1'b0, 48'h0, 8'h80, 8'h00, 32'h0}},
    '{1'b0, mktt_pkg::OP_OBSERVE, 48'hFFFF_FFFF_FFF1, 8'hC3, 8'h0B, 32'h0, 1, 1'b0,
      NONE_RESP},
    // Slots 0 and 1 now share the oldest time; the lower index is evicted.
    '{1'b0, mktt_pkg::OP_OBSERVE, 48'h5, 8'h01, 8'h24, 32'd9, 1, 1'b0, NONE_RESP},
    // An age exactly equal to the timeout survives the sweep.
    '{1'b0, mktt_pkg::OP_SWEEP,   48'h0, 8'h00, 8'h00, 32'd30000, 1, 1'b0, NONE_RESP},
    '{1'b1, mktt_pkg::OP_OBSERVE, 48'h0, 8'h00, 8'h00, 32'h0, 1, 1'b0, NONE_RESP},
    // With a zero timeout only slot 1, seen right now, is kept.
    '{1'b0, mktt_pkg::OP_SWEEP,   48'h0, 8'h00, 8'h00, 32'h0, 1, 1'b0, NONE_RESP},
    // Slot 0 is free but slot 1 holds this MAC, so slot 1 is updated.
    '{1'b0, mktt_pkg::OP_OBSERVE, 48'hFFFF_FFFF_FFF1, 8'hE2, 8'h95, 32'h0, 1, 1'b0,
      NONE_RESP},
    '{1'b0, mktt_pkg::OP_READ,    48'h0, 8'h00, 8'h00, 32'h0, 1, 1'b0, NONE_RESP},
    '{1'b1, mktt_pkg::OP_OBSERVE, 48'h0, 8'h00, 8'h00, 32'hFFFF_FFFF, 1, 1'b0, NONE_RESP},
    '{1'b0, mktt_pkg::OP_SWEEP,   48'h0, 8'h00, 8'h00, 32'hFFFF_FFFF, 1, 1'b0, NONE_RESP},
    '{1'b0, mktt_pkg::OP_CLEAR,   48'h0, 8'h00, 8'h00, 32'h0, 1, 1'b1, NONE_RESP},
    '{1'b0, mktt_pkg::OP_READ,    48'h0, 8'h00, 8'h00, 32'h0, 1, 1'b1, NONE_RESP}
  };

  mac_keyed_tracking_table_core #(
    .ENTRIES (ENTRIES)
  ) dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cfg_we_i        (cfg_we_i),
    .cfg_wdata_i     (cfg_wdata_i),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .operation_i     (operation_i),
    .mac_i           (mac_i),
    .rssi_i          (rssi_i),
    .channel_i       (channel_i),
    .now_ms_i        (now_ms_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .slot_o          (slot_o),
    .entry_status_o  (entry_status_o),
    .active_count_o  (active_count_o),
    .total_seen_o    (total_seen_o),
    .found_o         (found_o),
    .entry_mac_o     (entry_mac_o),
    .entry_rssi_o    (entry_rssi_o),
    .entry_channel_o (entry_channel_o),
    .entry_seen_ms_o (entry_seen_ms_o)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // Applies one operation to the shadow table and returns the result beat that
  // the block should produce for it.
  function automatic table_resp_t apply_table_op(mktt_pkg::op_e op, logic [47:0] mac,
                                                 logic [7:0] rssi, logic [7:0] chan,
                                                 logic [31:0] now);
    table_resp_t r;
    int          i, hit, free_idx, old_idx, pick;
    bit [31:0]   age;
    bit [4:0]    live;
    r    = NONE_RESP;
    live = '0;
    case (op)
      mktt_pkg::OP_OBSERVE: begin
        seen_total++;
        hit      = -1;
        free_idx = -1;
        old_idx  = -1;
        for (i = 0; i < ENTRIES; i++) begin
          if (shadow_valid[i]) begin
            if (hit < 0 && shadow_mac[i] == mac) hit = i;
            // Strictly smaller, so the lowest index wins a tie.
            if (old_idx < 0 || shadow_seen[i] < shadow_seen[old_idx]) old_idx = i;
          end else if (free_idx < 0) begin
            free_idx = i;
          end
        end
        if (hit >= 0) begin
          pick     = hit;
          r.status = mktt_pkg::STATUS_MATCHED;
        end else if (free_idx >= 0) begin
          pick     = free_idx;
          r.status = mktt_pkg::STATUS_NEW;
        end else begin
          pick     = old_idx;
          r.status = mktt_pkg::STATUS_EVICTED;
        end
        shadow_valid[pick] = 1'b1;
        shadow_mac[pick]   = mac;
        shadow_rssi[pick]  = rssi;
        shadow_chan[pick]  = chan;
        shadow_seen[pick]  = now;
        last_known         = 1'b1;
        last_idx           = pick;
        r.slot    = pick[3:0];
        r.total   = seen_total;
        r.mac     = mac;
        r.rssi    = rssi;
        r.chan    = chan;
        r.seen_ms = now;
      end
      mktt_pkg::OP_SWEEP: begin
        for (i = 0; i < ENTRIES; i++) begin
          if (shadow_valid[i]) begin
            // The age wraps at 32 bits, like the millisecond clock itself.
            age = now - shadow_seen[i];
            if (age > shadow_timeout) shadow_valid[i] = 1'b0;
            else live++;
          end
        end
        r.active = live;
        r.total  = seen_total;
      end
      mktt_pkg::OP_READ: begin
        r.total = seen_total;
        if (last_known && shadow_valid[last_idx]) begin
          r.slot    = last_idx[3:0];
          r.found   = 1'b1;
          r.mac     = shadow_mac[last_idx];
          r.rssi    = shadow_rssi[last_idx];
          r.chan    = shadow_chan[last_idx];
          r.seen_ms = shadow_seen[last_idx];
        end
      end
      default: begin
        for (i = 0; i < ENTRIES; i++) begin
          shadow_valid[i] = 1'b0;
          shadow_mac[i]   = '0;
          shadow_rssi[i]  = '0;
          shadow_chan[i]  = '0;
          shadow_seen[i]  = '0;
        end
        last_known = 1'b0;
        last_idx   = 0;
        seen_total = '0;
      end
    endcase
    return r;
  endfunction

  function automatic void check_response(table_resp_t got, table_resp_t want);
    if (got.slot !== want.slot) begin
      $error("slot: expected %0d, got %0d", want.slot, got.slot);
      error_count++;
    end
    if (got.status !== want.status) begin
      $error("entry_status: expected %0d, got %0d", want.status, got.status);
      error_count++;
    end
    if (got.active !== want.active) begin
      $error("active_count: expected %0d, got %0d", want.active, got.active);
      error_count++;
    end
    if (got.total !== want.total) begin
      $error("total_seen: expected %0d, got %0d", want.total, got.total);
      error_count++;
    end
    if (got.found !== want.found) begin
      $error("found: expected %0d, got %0d", want.found, got.found);
      error_count++;
    end
    if (got.mac !== want.mac) begin
      $error("entry_mac: expected %h, got %h", want.mac, got.mac);
      error_count++;
    end
    if (got.rssi !== want.rssi) begin
      $error("entry_rssi: expected %0d, got %0d", $signed(want.rssi), $signed(got.rssi));
      error_count++;
    end
    if (got.chan !== want.chan) begin
      $error("entry_channel: expected %0d, got %0d", want.chan, got.chan);
      error_count++;
    end
    if (got.seen_ms !== want.seen_ms) begin
      $error("entry_seen_ms: expected %0d, got %0d", want.seen_ms, got.seen_ms);
      error_count++;
    end
  endfunction

  // Both channels are sampled at the clock edge, before any of this edge's
  // nonblocking updates land, so the monitor sees exactly what the block sees.
  // The result side is handled first: with one beat in flight, a result leaving
  // at the same edge as an input beat arrives always belongs to an earlier beat.
  always @(posedge clk_i) begin : beat_monitor
    table_resp_t got, want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        got = '{slot_o, mktt_pkg::status_e'(entry_status_o), active_count_o, total_seen_o,
                found_o, entry_mac_o, entry_rssi_o, entry_channel_o, entry_seen_ms_o};
        if (response_q.size() == 0) begin
          $error("result beat arrived with no input beat outstanding");
          error_count++;
        end else begin
          check_response(got, response_q.pop_front());
        end
      end
      if (in_valid_i && in_ready_o) begin
        want = apply_table_op(mktt_pkg::op_e'(operation_i), mac_i, rssi_i, channel_i,
                              now_ms_i);
        // A hand-typed result replaces the prediction, but the shadow still advances.
        if (item_pinned) want = item_pinned_resp;
        response_q.push_back(want);
      end
    end
  end

  // Result side. Ready is redrawn every cycle; on request it is held low for a
  // long stretch so that a result sits in the output register and the block
  // stops taking beats while the sender keeps offering them.
  initial begin : result_sink
    forever begin
      @(posedge clk_i);
      if (hold_off_req) begin
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
        hold_off_req = 1'b0;
      end
      out_ready_i <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // Offers one beat and returns at the edge at which it is taken. Valid is only
  // lowered for idle cycles ahead of the beat, never in the step it is raised.
  task automatic send_op(mktt_pkg::op_e op, logic [47:0] mac, logic [7:0] rssi,
                         logic [7:0] chan, logic [31:0] now, bit pin,
                         table_resp_t pinned);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i       <= 1'b1;
    operation_i      <= op;
    mac_i            <= mac;
    rssi_i           <= rssi;
    channel_i        <= chan;
    now_ms_i         <= now;
    item_pinned      <= pin;
    item_pinned_resp <= pinned;
    do @(posedge clk_i); while (!in_ready_o);
  endtask

  // Stops offering beats and waits until every outstanding result has been taken.
  task automatic await_responses();
    in_valid_i <= 1'b0;
    do @(posedge clk_i); while (response_q.size() != 0);
  endtask

  // The timeout is only written with the block idle: all results in, and a quiet
  // wait with no beat offered after that for good measure.
  task automatic write_timeout(logic [31:0] value);
    await_responses();
    repeat (WALK_CYCLES) @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    shadow_timeout = value;
  endtask

  // Random traffic that behaves like a real receiver front end: a modest set of
  // transmitters seen again and again against a clock that moves forward, often
  // not at all between beats so that equal last-seen times occur. A small share
  // of beats carries an unknown MAC or a time from nowhere, and clears are rare
  // so that the table has time to fill up and evict.
  task automatic run_random_phase(int unsigned phase_no);
    int unsigned   k, pick;
    mktt_pkg::op_e op;
    logic [47:0]   mac;
    logic [31:0]   now;
    for (k = 0; k < PHASE_ITEMS; k++) begin
      if ((phase_no == 0 && k == 40) || (phase_no == 4 && k == 60)) hold_off_req = 1'b1;
      if (phase_no == 2 && k == 100) await_responses();
      if ($urandom_range(3) != 0) clock_ms += $urandom_range(60, 1);
      if ($urandom_range(99) == 0) clock_ms += $urandom;
      pick = $urandom_range(99);
      if (pick < 66)      op = mktt_pkg::OP_OBSERVE;
      else if (pick < 80) op = mktt_pkg::OP_SWEEP;
      else if (pick < 99) op = mktt_pkg::OP_READ;
      else                op = mktt_pkg::OP_CLEAR;
      if ($urandom_range(9) == 0) mac = {16'($urandom), $urandom};
      else                        mac = mac_pool[$urandom_range(MAC_POOL - 1)];
      now = ($urandom_range(19) == 0) ? $urandom : clock_ms;
      send_op(op, mac, 8'($urandom), 8'($urandom), now, 1'b0, NONE_RESP);
    end
  endtask

  initial begin : stimulus
    int unsigned row, k, phase_no;
    logic [31:0] tmo;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    for (row = 0; row < $size(directed_rows); row++) begin
      if (directed_rows[row].cfg) begin
        write_timeout(directed_rows[row].now);
      end else begin
        for (k = 0; k < directed_rows[row].reps; k++) begin
          send_op(directed_rows[row].op, directed_rows[row].mac + k,
                  directed_rows[row].rssi, directed_rows[row].chan,
                  directed_rows[row].now, directed_rows[row].pinned,
                  directed_rows[row].resp);
        end
      end
    end

    foreach (mac_pool[i]) mac_pool[i] = {16'($urandom), $urandom};

    // Two phases each of receiver-heavy idling, sender-heavy idling and none,
    // with a fresh timeout per phase. The all-ones timeout phase starts its
    // clock just short of the wrap so that ages are taken across it.
    for (phase_no = 0; phase_no < PHASES; phase_no++) begin
      case (phase_no / 2)
        0: begin
          send_idle_pct = 27;
          recv_idle_pct = 45;
        end
        1: begin
          send_idle_pct = 45;
          recv_idle_pct = 27;
        end
        default: begin
          send_idle_pct = 0;
          recv_idle_pct = 0;
        end
      endcase
      case (phase_no)
        0:       tmo = 32'd40;
        1:       tmo = 32'd1000;
        2:       tmo = 32'd0;
        3:       tmo = 32'hFFFF_FFFF;
        4:       tmo = mktt_pkg::TIMEOUT_RESET;
        default: tmo = $urandom_range(200, 1);
      endcase
      write_timeout(tmo);
      clock_ms = (phase_no == 3) ? 32'hFFFF_F000 : $urandom;
      run_random_phase(phase_no);
    end

    await_responses();
    repeat (2 * WALK_CYCLES) @(posedge clk_i);
    if (error_count == 0 && response_q.size() == 0) begin
      $display("[mac_keyed_tracking_table_core] OK");
    end else begin
      if (response_q.size() != 0) $error("%0d results never arrived", response_q.size());
      $display("[mac_keyed_tracking_table_core] ERROR");
    end
    $finish;
  end

  // Guard against a hung handshake; far beyond the slowest correct run.
  initial begin : watchdog
    #5_000_000;
    $display("[mac_keyed_tracking_table_core] ERROR");
    $finish;
  end

endmodule

### mac_keyed_tracking_table_core.f
rtl/core/mktt_pkg.sv
rtl/core/mktt_eval.sv
rtl/core/mac_keyed_tracking_table_core.sv
tb/mac_keyed_tracking_table_core_tb.sv
